### hdl/rgbe_rle_pkg.sv
// Package with the types and constants of the RGBE scanline run-length decoder.
package rgbe_rle_pkg;

    localparam int BYTE_BITS    = 8;
    localparam int STATUS_BITS  = 2;
    localparam int CHANNEL_BITS = 2;
    localparam int X_BITS       = 15;
    localparam int COUNT_BITS   = 7;
    localparam int HDR_BITS     = 16;

    localparam logic [BYTE_BITS-1:0]    HDR_MARK   = 8'd2;
    localparam logic [BYTE_BITS-1:0]    RUN_FLAG   = 8'd128;
    localparam logic [CHANNEL_BITS-1:0] LAST_PLANE = 2'd3;

    localparam logic [STATUS_BITS-1:0] STATUS_WRITE    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_HDR_ERR  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_OVERRUN  = 2'd2;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_HDR2    = 3'd2,
        PH_HDR3    = 3'd3,
        PH_COUNT   = 3'd4,
        PH_RUNVAL  = 3'd5,
        PH_LITERAL = 3'd6
    } phase_t;

endpackage

### hdl/rgbe_scanline_rle_decoder.sv
// Top level of the RGBE adaptive run-length scanline decoder.
//
// The block takes one byte of a new-style RGBE scanline per transaction and checks the
// four-byte header (2, 2, then a big-endian length equal to scan_length). It then decodes
// the red, green, blue and exponent planes, giving one write command per run value or
// literal byte. Status 1 reports a header mismatch and status 2 a run or literal that would
// pass the scan length; after either, or after a finished line, a new header is expected.
// One byte is accepted per cycle unless the output register holds a result that is not
// taken: the decode state is updated by a single combinational step and the result is held
// in one output register, so a result shows in the cycle after its byte is accepted.
// scan_length is written through cfg_wen and cfg_wdata and takes effect at once.
module rgbe_scanline_rle_decoder #(
    parameter int LENGTH_BITS = 15
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wen,
    input  logic [LENGTH_BITS-1:0] cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: byte_value[7:0].
    input  logic [rgbe_rle_pkg::BYTE_BITS-1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: channel[1:0], start_x[16:2], run_count[23:17], run_value[31:24].
    output logic [31:0]            m_tdata,
    // Fields from bit 0: status[1:0].
    output logic [rgbe_rle_pkg::STATUS_BITS-1:0] m_tuser,
    output logic                   m_tlast
);
    import rgbe_rle_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [CHANNEL_BITS-1:0] plane_reg, plane_next;
    logic [LENGTH_BITS-1:0]  position_reg, position_next;
    logic [BYTE_BITS-1:0]    remaining_reg, remaining_next;
    logic [BYTE_BITS-1:0]    length_high_reg, length_high_next;
    logic [LENGTH_BITS-1:0]  scan_length_reg;

    logic                    m_valid_reg;
    logic [STATUS_BITS-1:0]  status_reg, status_next;
    logic [CHANNEL_BITS-1:0] channel_reg, channel_next;
    logic [X_BITS-1:0]       start_x_reg, start_x_next;
    logic [COUNT_BITS-1:0]   run_count_reg, run_count_next;
    logic [BYTE_BITS-1:0]    run_value_reg, run_value_next;
    logic                    line_done_reg, line_done_next;
    logic                    res_valid;

    logic                    accept;
    logic [BYTE_BITS-1:0]    b;
    logic                    is_run;
    logic [BYTE_BITS-1:0]    count_n;
    logic [LENGTH_BITS:0]    ovf_sum;
    logic                    overrun;
    logic [BYTE_BITS-1:0]    write_cnt;
    logic [LENGTH_BITS-1:0]  pos_adv;
    logic                    plane_end;
    logic                    lit_last;
    logic                    hdr_ok;
    logic                    line_end;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;

    assign is_run    = b > RUN_FLAG;
    assign count_n   = is_run ? {1'b0, b[COUNT_BITS-1:0]} : b;
    assign ovf_sum   = (LENGTH_BITS+1)'(position_reg) + (LENGTH_BITS+1)'(count_n);
    assign overrun   = ovf_sum > {1'b0, scan_length_reg};
    assign write_cnt = (phase_reg == PH_RUNVAL) ? {1'b0, remaining_reg[COUNT_BITS-1:0]}
                                                : 8'd1;
    assign pos_adv   = position_reg + LENGTH_BITS'(write_cnt);
    assign plane_end = pos_adv >= scan_length_reg;
    assign lit_last  = remaining_reg == 8'd1;
    assign hdr_ok    = (scan_length_reg != '0)
                    && ({length_high_reg, b} == HDR_BITS'(scan_length_reg));
    assign line_end  = ((phase_reg == PH_RUNVAL) || lit_last) && plane_end
                    && (plane_reg == LAST_PLANE);

    // Next decode state for an accepted byte.
    always_comb begin
        phase_next       = phase_reg;
        plane_next       = plane_reg;
        position_next    = position_reg;
        remaining_next   = remaining_reg;
        length_high_next = length_high_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_HDR0, PH_HDR1: begin
                    if (b != HDR_MARK) begin
                        phase_next       = PH_HDR0;
                        plane_next       = '0;
                        position_next    = '0;
                        remaining_next   = '0;
                        length_high_next = '0;
                    end else begin
                        phase_next = (phase_reg == PH_HDR0) ? PH_HDR1 : PH_HDR2;
                    end
                end
                PH_HDR2: begin
                    length_high_next = b;
                    phase_next       = PH_HDR3;
                end
                PH_HDR3: begin
                    plane_next    = '0;
                    position_next = '0;
                    if (!hdr_ok) begin
                        phase_next       = PH_HDR0;
                        remaining_next   = '0;
                        length_high_next = '0;
                    end else begin
                        phase_next = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    if (count_n != '0) begin
                        if (overrun) begin
                            phase_next       = PH_HDR0;
                            plane_next       = '0;
                            position_next    = '0;
                            remaining_next   = '0;
                            length_high_next = '0;
                        end else begin
                            remaining_next = count_n;
                            phase_next     = is_run ? PH_RUNVAL : PH_LITERAL;
                        end
                    end
                end
                PH_RUNVAL, PH_LITERAL: begin
                    position_next  = pos_adv;
                    remaining_next = (phase_reg == PH_RUNVAL) ? '0 : remaining_reg - 8'd1;
                    if ((phase_reg == PH_RUNVAL) || lit_last) begin
                        phase_next = PH_COUNT;
                        if (plane_end) begin
                            if (plane_reg == LAST_PLANE) begin
                                phase_next       = PH_HDR0;
                                plane_next       = '0;
                                remaining_next   = '0;
                                length_high_next = '0;
                            end else begin
                                plane_next = plane_reg + 2'd1;
                            end
                            position_next = '0;
                        end
                    end
                end
                default: begin
                    phase_next       = PH_HDR0;
                    plane_next       = '0;
                    position_next    = '0;
                    remaining_next   = '0;
                    length_high_next = '0;
                end
            endcase
        end
    end

    // Result produced by an accepted byte.
    always_comb begin
        res_valid      = 1'b0;
        status_next    = STATUS_WRITE;
        channel_next   = plane_reg;
        start_x_next   = X_BITS'(position_reg);
        run_count_next = '0;
        run_value_next = b;
        line_done_next = 1'b0;
        unique case (phase_reg)
            PH_HDR0, PH_HDR1: begin
                res_valid   = b != HDR_MARK;
                status_next = STATUS_HDR_ERR;
            end
            PH_HDR2: begin
                res_valid = 1'b0;
            end
            PH_HDR3: begin
                res_valid   = !hdr_ok;
                status_next = STATUS_HDR_ERR;
            end
            PH_COUNT: begin
                res_valid   = (count_n != '0) && overrun;
                status_next = STATUS_OVERRUN;
            end
            PH_RUNVAL, PH_LITERAL: begin
                res_valid      = 1'b1;
                run_count_next = write_cnt[COUNT_BITS-1:0];
                line_done_next = line_end;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HDR0;
            plane_reg       <= '0;
            position_reg    <= '0;
            remaining_reg   <= '0;
            length_high_reg <= '0;
            scan_length_reg <= LENGTH_BITS'(1);
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            plane_reg       <= plane_next;
            position_reg    <= position_next;
            remaining_reg   <= remaining_next;
            length_high_reg <= length_high_next;
            if (cfg_wen) begin
                scan_length_reg <= cfg_wdata;
            end
            if (accept) begin
                m_valid_reg <= res_valid;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            status_reg    <= status_next;
            channel_reg   <= channel_next;
            start_x_reg   <= start_x_next;
            run_count_reg <= run_count_next;
            run_value_reg <= run_value_next;
            line_done_reg <= line_done_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {run_value_reg, run_count_reg, start_x_reg, channel_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = line_done_reg;

endmodule

### bench/rgbe_write_checker.sv
// Checker that predicts and compares the write commands of the RGBE scanline decoder.
`timescale 1ns / 1ps

module rgbe_write_checker (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wen,
    input  logic [rgbe_rle_pkg::X_BITS-1:0]         cfg_wdata,
    input  logic                                    s_tvalid,
    input  logic                                    s_tready,
    input  logic [rgbe_rle_pkg::BYTE_BITS-1:0]      s_tdata,
    input  logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic [31:0]                             m_tdata,
    input  logic [rgbe_rle_pkg::STATUS_BITS-1:0]    m_tuser,
    input  logic                                    m_tlast,
    output int                                      pending_writes,
    output int                                      error_count
);
    import rgbe_rle_pkg::*;

    typedef struct packed {
        logic [STATUS_BITS-1:0]  status;
        logic [CHANNEL_BITS-1:0] channel;
        logic [X_BITS-1:0]       start_x;
        logic [COUNT_BITS-1:0]   run_count;
        logic [BYTE_BITS-1:0]    run_value;
        logic                    line_done;
    } write_cmd_t;

    write_cmd_t expected_writes[$];

    phase_t                  ph;
    logic [CHANNEL_BITS-1:0] plane;
    logic [X_BITS-1:0]       pos;
    logic [7:0]              remaining;
    logic [7:0]              length_high;
    logic [X_BITS-1:0]       scan_len;

    function automatic void restart_line();
        ph = PH_HDR0;
        plane = '0;
        pos = '0;
        remaining = '0;
        length_high = '0;
    endfunction

    // Ends the plane once the position has reached the scan length, and the line after the last plane.
    function automatic logic plane_end_check();
        if (pos >= scan_len) begin
            if (plane == LAST_PLANE) begin
                restart_line();
                return 1'b1;
            end
            plane = plane + 2'd1;
            pos = '0;
        end
        return 1'b0;
    endfunction

    function automatic void push_error(input logic [STATUS_BITS-1:0] st, input logic [7:0] b);
        write_cmd_t w;
        w.status = st;
        w.channel = plane;
        w.start_x = pos;
        w.run_count = '0;
        w.run_value = b;
        w.line_done = 1'b0;
        expected_writes.push_back(w);
        restart_line();
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        write_cmd_t w;
        int n;
        w = '0;
        case (ph)
            PH_HDR0, PH_HDR1: begin
                if (b != HDR_MARK) begin
                    push_error(STATUS_HDR_ERR, b);
                end else begin
                    ph = (ph == PH_HDR0) ? PH_HDR1 : PH_HDR2;
                end
            end
            PH_HDR2: begin
                length_high = b;
                ph = PH_HDR3;
            end
            PH_HDR3: begin
                if (scan_len == '0 || {length_high, b} != {1'b0, scan_len}) begin
                    push_error(STATUS_HDR_ERR, b);
                end else begin
                    plane = '0;
                    pos = '0;
                    ph = PH_COUNT;
                end
            end
            PH_COUNT: begin
                n = (b > RUN_FLAG) ? int'(b[6:0]) : int'(b);
                if (n != 0) begin
                    if (int'(pos) + n > int'(scan_len)) begin
                        push_error(STATUS_OVERRUN, b);
                    end else begin
                        remaining = n[7:0];
                        ph = (b > RUN_FLAG) ? PH_RUNVAL : PH_LITERAL;
                    end
                end
            end
            PH_RUNVAL: begin
                w.status = STATUS_WRITE;
                w.channel = plane;
                w.start_x = pos;
                w.run_count = remaining[6:0];
                w.run_value = b;
                pos = pos + X_BITS'(remaining[6:0]);
                remaining = '0;
                ph = PH_COUNT;
                w.line_done = plane_end_check();
                expected_writes.push_back(w);
            end
            PH_LITERAL: begin
                w.status = STATUS_WRITE;
                w.channel = plane;
                w.start_x = pos;
                w.run_count = 7'd1;
                w.run_value = b;
                pos = pos + 1'b1;
                remaining = remaining - 8'd1;
                if (remaining == 8'd0) begin
                    ph = PH_COUNT;
                    w.line_done = plane_end_check();
                end
                expected_writes.push_back(w);
            end
            default: restart_line();
        endcase
    endfunction

    always @(posedge aclk) begin
        write_cmd_t exp_w;
        write_cmd_t act_w;
        if (!aresetn) begin
            expected_writes.delete();
            scan_len = 15'd1;
            restart_line();
        end else begin
            if (m_tvalid && m_tready) begin
                act_w.status = m_tuser;
                act_w.channel = m_tdata[1:0];
                act_w.start_x = m_tdata[16:2];
                act_w.run_count = m_tdata[23:17];
                act_w.run_value = m_tdata[31:24];
                act_w.line_done = m_tlast;
                if (expected_writes.size() == 0) begin
                    if (error_count < 10)
                        $display("%0t: extra st=%0d ch=%0d x=%0d n=%0d v=%0d last=%0d",
                                 $realtime, act_w.status, act_w.channel, act_w.start_x,
                                 act_w.run_count, act_w.run_value, act_w.line_done);
                    error_count = error_count + 1;
                end else begin
                    exp_w = expected_writes.pop_front();
                    if (act_w !== exp_w) begin
                        if (error_count < 10) begin
                            $display("%0t: expected st=%0d ch=%0d x=%0d n=%0d v=%0d last=%0d",
                                     $realtime, exp_w.status, exp_w.channel, exp_w.start_x,
                                     exp_w.run_count, exp_w.run_value, exp_w.line_done);
                            $display("%0t: actual   st=%0d ch=%0d x=%0d n=%0d v=%0d last=%0d",
                                     $realtime, act_w.status, act_w.channel, act_w.start_x,
                                     act_w.run_count, act_w.run_value, act_w.line_done);
                        end
                        error_count = error_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
            if (cfg_wen)
                scan_len = cfg_wdata;
        end
        pending_writes = expected_writes.size();
    end

endmodule

### bench/tb_top.sv
// Top of the testbench that drives encoded scanlines into the RGBE decoder and gives the verdict.
`timescale 1ns / 1ps

module tb_top;
    import rgbe_rle_pkg::*;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wen = 1'b0;
    logic [X_BITS-1:0]       cfg_wdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [BYTE_BITS-1:0]    s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [31:0]             m_tdata;
    logic [STATUS_BITS-1:0]  m_tuser;
    logic                    m_tlast;

    int  pending_writes;
    int  error_count;
    bit  no_idle = 1'b0;
    int  bytes_sent = 0;

    logic [7:0] byte_stream[$];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    rgbe_scanline_rle_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    rgbe_write_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .pending_writes (pending_writes),
        .error_count    (error_count)
    );

    // The receiver draws a fresh stall after every accepted result.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                stall = no_idle ? 0 : $urandom_range(0, 5);
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall = stall - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic feed_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic feed_stream();
        while (byte_stream.size() > 0)
            feed_byte(byte_stream.pop_front());
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_bytes(input logic [7:0] seq[]);
        foreach (seq[i])
            byte_stream.push_back(seq[i]);
        feed_stream();
    endtask

    task automatic set_scan_length(input logic [X_BITS-1:0] len);
        while (pending_writes != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= len;
        @(negedge aclk);
        cfg_wen <= 1'b0;
    endtask

    // Builds one encoded line. Lines over 300 are cut after 10 segments of a plane, others after 64.
    task automatic build_line(input int hdr_len, input int body_len);
        int pl;
        int p;
        int rem;
        int n;
        int seg;
        int seg_cap;
        byte_stream.push_back(HDR_MARK);
        byte_stream.push_back(HDR_MARK);
        byte_stream.push_back(hdr_len[15:8]);
        byte_stream.push_back(hdr_len[7:0]);
        seg_cap = (body_len > 300) ? 10 : 64;
        for (pl = 0; pl < 4 && body_len > 0; pl++) begin
            p = 0;
            seg = 0;
            while (p < body_len && seg < seg_cap) begin
                rem = body_len - p;
                if ($urandom_range(0, 15) == 0)
                    byte_stream.push_back(8'd0);
                if ($urandom_range(0, 1) == 1) begin
                    n = $urandom_range(1, (rem < 127) ? rem : 127);
                    byte_stream.push_back(RUN_FLAG | n[7:0]);
                    byte_stream.push_back(8'($urandom_range(0, 255)));
                end else begin
                    if (rem >= 128 && $urandom_range(0, 3) == 0)
                        n = 128;
                    else
                        n = $urandom_range(1, (rem < 8) ? rem : 8);
                    byte_stream.push_back(n[7:0]);
                    repeat (n) byte_stream.push_back(8'($urandom_range(0, 255)));
                end
                p = p + n;
                seg = seg + 1;
            end
            if (p < body_len)
                return;
        end
    endtask

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int len;
        int hdr_len;
        int k;
        int pick;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // A full one-pixel line with runs, literals and a zero count byte.
        send_bytes('{8'd2, 8'd2, 8'd0, 8'd1, 8'h81, 8'hA5, 8'h00, 8'h01, 8'hFF,
                     8'h81, 8'h00, 8'h01, 8'h5A});
        // Header mismatches on the first, second and fourth header bytes, then a count of 128 that overruns.
        send_bytes('{8'd3, 8'd2, 8'hFD, 8'd2, 8'd2, 8'hFF, 8'hFF,
                     8'd2, 8'd2, 8'd0, 8'd1, 8'h80});
        set_scan_length(15'd0);
        send_bytes('{8'd2, 8'd2, 8'd0, 8'd0});
        // Longest line, then a shorter length that ends the plane mid-line.
        set_scan_length(15'h7FFF);
        send_bytes('{8'd2, 8'd2, 8'h7F, 8'hFF, 8'hFF, 8'h11, 8'h81});
        set_scan_length(15'd100);
        send_bytes('{8'h22});

        while (bytes_sent < 900) begin
            pick = $urandom_range(0, 19);
            case (pick)
                0: len = 0;
                1: len = 32767;
                2: len = $urandom_range(128, 300);
                3: len = 1;
                default: len = $urandom_range(2, 40);
            endcase
            set_scan_length(len[X_BITS-1:0]);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) begin
                hdr_len = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 65535) : len;
                build_line(hdr_len, len);
                if ($urandom_range(0, 7) == 0) begin
                    k = $urandom_range(0, byte_stream.size() - 1);
                    byte_stream[k] = 8'($urandom_range(0, 255));
                end
                if ($urandom_range(0, 15) == 0) begin
                    k = $urandom_range(1, byte_stream.size());
                    while (byte_stream.size() > k) void'(byte_stream.pop_back());
                end
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 6))
                        byte_stream.push_back(8'($urandom_range(0, 255)));
                bytes_sent = bytes_sent + byte_stream.size();
                feed_stream();
            end
        end

        while (pending_writes != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
